/* rtl/qxm_pkg.sv */
// qxm_pkg: shared types, register codes and the square-root digit step
// for the x-quad motor mixer; no dependencies
package qxm_pkg;

   // demand sum, scaled motor value, shared correction, unsigned thrust
   typedef logic signed [18:0] mix_type;
   typedef logic signed [20:0] motor_type;
   typedef logic signed [22:0] corr_type;
   typedef logic [15:0]        unit_type;

   typedef enum logic [1:0] {
      CSR_EXPO   = 2'd0,
      CSR_OFFSET = 2'd1
   } csr_idx_type;

   localparam int unsigned EXPO_MAX    = 1000;
   localparam int unsigned SQRT_STAGES = 8;

   // floor(x / 1000) = (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2^26
   localparam logic [26:0] DIV_MUL   = 27'd68719477;
   localparam int unsigned DIV_SHIFT = 36;

   typedef struct packed {
      logic [16:0] rem;
      unit_type    root;
   } sq_type;

   // one restoring digit of the integer square root
   function automatic sq_type sqrt_step(sq_type cur, logic [1:0] bits);
      logic [18:0] r;
      logic [18:0] trial;
      sq_type      nxt;
      r     = {cur.rem, bits};
      trial = {1'b0, cur.root, 2'b01};
      if (r >= trial) begin
         r        = r - trial;
         nxt.root = {cur.root[14:0], 1'b1};
      end else begin
         nxt.root = {cur.root[14:0], 1'b0};
      end
      nxt.rem = r[16:0];
      return nxt;
   endfunction

endpackage

/* rtl/qxm_sqrt_pipe.sv */
// qxm_sqrt_pipe: pipelined exact 32-bit integer square root, two digits per stage
// depends on qxm_pkg
module qxm_sqrt_pipe
   import qxm_pkg::*;
(
   input  logic                   clock,
   input  logic [SQRT_STAGES-1:0] ld,
   input  logic [31:0]            rad,
   output unit_type               root
);

   logic [31:0] rad_ff [SQRT_STAGES];
   sq_type      sq_ff  [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic [31:0] rad_src;
      sq_type      sq_src;
      sq_type      mid;
      sq_type      sq_in;
      if (s == 0) begin : g_first
         assign rad_src = rad;
         assign sq_src  = '0;
      end else begin : g_next
         assign rad_src = rad_ff[s-1];
         assign sq_src  = sq_ff[s-1];
      end
      always_comb begin
         mid   = sqrt_step(sq_src, rad_src[31-4*s -: 2]);
         sq_in = sqrt_step(mid, rad_src[29-4*s -: 2]);
      end
      always_ff @(posedge clock) begin
         if (ld[s]) begin
            rad_ff[s] <= rad_src;
            sq_ff[s]  <= sq_in;
         end
      end
   end

   assign root = sq_ff[SQRT_STAGES-1].root;

endmodule

/* rtl/quad_x_motor_mixer.sv */
// quad_x_motor_mixer: x-quad motor mixer with desaturation and sqrt thrust blend
// depends on qxm_pkg and qxm_sqrt_pipe
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | armed, throttle, pitch, roll, yaw, gain
//  rsp     | out       | rsp_valid/rsp_stall | four 13-bit motor counts
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// 18 register stages, one item per cycle while rsp_stall is low
// the square root takes eight of them, two digits per stage
// reset clears valid bits and loads the register defaults
// each stage holds while the one after it is full and stalled, so bubbles
// are squeezed out and req_stall rises only when all 18 stages are full
module quad_x_motor_mixer
   import qxm_pkg::*;
#(
   parameter int unsigned FULL_SCALE = 1000
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_armed,
   input  logic signed [15:0] req_throttle,
   input  logic signed [15:0] req_pitch,
   input  logic signed [15:0] req_roll,
   input  logic signed [15:0] req_yaw,
   input  logic [15:0]        req_battery_gain,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [12:0]        rsp_motor_front_a,
   output logic [12:0]        rsp_motor_front_b,
   output logic [12:0]        rsp_motor_rear_a,
   output logic [12:0]        rsp_motor_rear_b,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   // full scale in 1/16 counts
   localparam int unsigned FS16   = FULL_SCALE * 16;
   localparam corr_type    F_CORR = corr_type'(FS16);
   localparam unit_type    F_UNIT = unit_type'(FS16);
   localparam int unsigned NST    = 18;
   localparam int unsigned SQ_LO  = 7;
   localparam int unsigned SQ_HI  = SQ_LO + SQRT_STAGES - 1;

   // ---------------- configuration registers ----------------
   logic [9:0]  expo_ff;
   logic [11:0] offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expo_ff   <= '0;
         offset_ff <= 12'd1000;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_EXPO:   expo_ff   <= csr_wdata[9:0];
            CSR_OFFSET: offset_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // ---------------- stage valid bits and load enables ----------------
   logic [NST:1]   vld_ff;
   logic [NST+1:1] ld;

   assign ld[NST+1] = !rsp_stall;
   for (genvar k = 1; k <= NST; k++) begin : g_ld
      assign ld[k] = !vld_ff[k] || ld[k+1];
   end
   assign req_stall = !ld[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[1]) vld_ff[1] <= req_valid;
         for (int k = 2; k <= NST; k++) begin
            if (ld[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // armed flag rides along every stage
   logic [NST:1] arm_ff;
   always_ff @(posedge clock) begin
      if (ld[1]) arm_ff[1] <= req_armed;
      for (int k = 2; k <= NST; k++) begin
         if (ld[k]) arm_ff[k] <= arm_ff[k-1];
      end
   end

   // ---------------- stage 1: mix the demands ----------------
   mix_type  mix_in [4];
   mix_type  mix_ff [4];
   logic [15:0] gain_ff;
   always_comb begin
      mix_type t, p, r, y;
      t = mix_type'(req_throttle);
      p = mix_type'(req_pitch);
      r = mix_type'(req_roll);
      y = mix_type'(req_yaw);
      mix_in[0] = t - p - r + y;
      mix_in[1] = t - p + r - y;
      mix_in[2] = t + p - r - y;
      mix_in[3] = t + p + r + y;
   end
   always_ff @(posedge clock) begin
      if (ld[1]) begin
         mix_ff  <= mix_in;
         gain_ff <= req_battery_gain;
      end
   end

   // ---------------- stage 2: battery gain, floor to q.4 ----------------
   motor_type mot2_in [4];
   motor_type mot2_ff [4];
   always_comb begin
      logic signed [35:0] prod;
      for (int i = 0; i < 4; i++) begin
         prod = 36'(mix_ff[i]) * 36'($signed({1'b0, gain_ff}));
         mot2_in[i] = prod[34:14];
      end
   end
   always_ff @(posedge clock) begin
      if (ld[2]) mot2_ff <= mot2_in;
   end

   // ---------------- stage 3: min and max of the set ----------------
   motor_type mot3_ff [4];
   motor_type mn_in, mx_in, mn_ff, mx_ff;
   always_comb begin
      motor_type lo01, hi01, lo23, hi23;
      lo01  = (mot2_ff[0] < mot2_ff[1]) ? mot2_ff[0] : mot2_ff[1];
      hi01  = (mot2_ff[0] < mot2_ff[1]) ? mot2_ff[1] : mot2_ff[0];
      lo23  = (mot2_ff[2] < mot2_ff[3]) ? mot2_ff[2] : mot2_ff[3];
      hi23  = (mot2_ff[2] < mot2_ff[3]) ? mot2_ff[3] : mot2_ff[2];
      mn_in = (lo01 < lo23) ? lo01 : lo23;
      mx_in = (hi01 > hi23) ? hi01 : hi23;
   end
   always_ff @(posedge clock) begin
      if (ld[3]) begin
         mot3_ff <= mot2_ff;
         mn_ff   <= mn_in;
         mx_ff   <= mx_in;
      end
   end

   // ---------------- stage 4: shared desaturation correction ----------------
   motor_type mot4_ff [4];
   corr_type  corr_in, corr_ff;
   always_comb begin
      corr_type mnx, mxx, c0, half;
      mnx  = corr_type'(mn_ff);
      mxx  = corr_type'(mx_ff);
      c0   = (mnx < 0) ? -mnx : '0;
      half = F_CORR - mxx - mnx;
      if (mxx - mnx <= F_CORR) begin
         // span fits: lift off zero, then pull down under full scale
         corr_in = (mxx + c0 > F_CORR) ? F_CORR - mxx : c0;
      end else begin
         // span too wide: center the set
         corr_in = half >>> 1;
      end
   end
   always_ff @(posedge clock) begin
      if (ld[4]) begin
         mot4_ff <= mot3_ff;
         corr_ff <= corr_in;
      end
   end

   // ---------------- stage 5: apply and clamp to 0..full scale ----------------
   unit_type u5_in [4];
   unit_type u5_ff [4];
   always_comb begin
      logic signed [23:0] v;
      for (int i = 0; i < 4; i++) begin
         v = 24'(mot4_ff[i]) + 24'(corr_ff);
         if (v < 0)                  u5_in[i] = '0;
         else if (v > 24'(F_CORR))   u5_in[i] = F_UNIT;
         else                        u5_in[i] = v[15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (ld[5]) u5_ff <= u5_in;
   end

   // ---------------- stage 6: radicand u * full scale ----------------
   logic [31:0] rad_in [4];
   logic [31:0] rad_ff [4];
   always_comb begin
      for (int i = 0; i < 4; i++) rad_in[i] = 32'(u5_ff[i]) * 32'(F_UNIT);
   end

   // linear value carried alongside the root pipeline
   unit_type u_ff [SQ_HI:6][4];
   always_ff @(posedge clock) begin
      if (ld[6]) begin
         rad_ff   <= rad_in;
         u_ff[6]  <= u5_ff;
      end
      for (int k = SQ_LO; k <= SQ_HI; k++) begin
         if (ld[k]) u_ff[k] <= u_ff[k-1];
      end
   end

   // ---------------- stages 7..14: square root per motor ----------------
   unit_type root [4];
   for (genvar i = 0; i < 4; i++) begin : g_sqrt
      qxm_sqrt_pipe u_sqrt (
         .clock (clock),
         .ld    (ld[SQ_HI:SQ_LO]),
         .rad   (rad_ff[i]),
         .root  (root[i])
      );
   end

   // ---------------- stage 15: blend weights ----------------
   logic [25:0] lin_in [4];
   logic [25:0] sq_in  [4];
   logic [25:0] lin_ff [4];
   logic [25:0] sq_ff  [4];
   logic [9:0]  g_eff;
   // out-of-range gain means no blend
   assign g_eff = (expo_ff > 10'(EXPO_MAX)) ? '0 : expo_ff;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lin_in[i] = 26'(10'(EXPO_MAX) - g_eff) * 26'(u_ff[SQ_HI][i]);
         sq_in[i]  = 26'(g_eff) * 26'(root[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (ld[15]) begin
         lin_ff <= lin_in;
         sq_ff  <= sq_in;
      end
   end

   // ---------------- stage 16: weighted sum ----------------
   logic [25:0] sum_ff [4];
   always_ff @(posedge clock) begin
      if (ld[16]) begin
         for (int i = 0; i < 4; i++) sum_ff[i] <= lin_ff[i] + sq_ff[i];
      end
   end

   // ---------------- stage 17: divide by 1000 via reciprocal ----------------
   unit_type q_in [4];
   unit_type q_ff [4];
   always_comb begin
      logic [52:0] prod;
      for (int i = 0; i < 4; i++) begin
         prod    = 53'(sum_ff[i]) * 53'(DIV_MUL);
         q_in[i] = prod[DIV_SHIFT+15:DIV_SHIFT];
      end
   end
   always_ff @(posedge clock) begin
      if (ld[17]) q_ff <= q_in;
   end

   // ---------------- stage 18: whole counts plus offset ----------------
   logic [12:0] out_in [4];
   logic [12:0] out_ff [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_in[i] = arm_ff[17] ? 13'(q_ff[i][15:4]) + 13'(offset_ff) : 13'(offset_ff);
      end
   end
   always_ff @(posedge clock) begin
      if (ld[18]) out_ff <= out_in;
   end

   assign rsp_valid         = vld_ff[NST];
   assign rsp_motor_front_a = out_ff[0];
   assign rsp_motor_front_b = out_ff[1];
   assign rsp_motor_rear_a  = out_ff[2];
   assign rsp_motor_rear_b  = out_ff[3];

   // ---------------- assertions ----------------
   // input side only backs up when the whole pipe is full behind a stalled output
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && vld_ff[1]))
      else $error("input stalled with room in the pipe");

   // clamped value never exceeds full scale
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (u5_ff[0] <= F_UNIT && u5_ff[1] <= F_UNIT &&
                     u5_ff[2] <= F_UNIT && u5_ff[3] <= F_UNIT))
      else $error("clamped motor value above full scale");

   // disarmed output gives the idle offset on front_a and rear_b
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !arm_ff[NST]) |->
         (rsp_motor_front_a == 13'(offset_ff) && rsp_motor_rear_b == 13'(offset_ff)))
      else $error("disarmed output differs from offset");

   // a stalled stage 10 keeps its valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[10] && !ld[10]) |=> vld_ff[10])
      else $error("stalled stage lost its item");

endmodule
